@@ hdl/cpio_newc_stream_parser_macros.svh @@
// Assertion macros for the newc cpio stream parser.
// Included by the top level; no other dependencies.
`ifndef CPIO_NEWC_STREAM_PARSER_MACROS_SVH
`define CPIO_NEWC_STREAM_PARSER_MACROS_SVH

`ifndef SYNTH
// Clocked property, masked while reset is asserted
`define CPIO_ASSERT(lbl, clk_i, rst_n_i, prop, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) prop) else $error(msg);
// Clocked property, checked during reset as well
`define CPIO_ASSERT_ALWAYS(lbl, clk_i, prop, msg) \
	lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define CPIO_ASSERT(lbl, clk_i, rst_n_i, prop, msg)
`define CPIO_ASSERT_ALWAYS(lbl, clk_i, prop, msg)
`endif

`endif

@@ hdl/cpio_pkg.sv @@
// Shared types, constants and helper functions for the newc cpio stream parser.
// No dependencies.
package cpio_pkg;

	// newc header layout
	localparam int unsigned HDR_LEN     = 110;
	localparam int unsigned FSIZE_POS   = 54;
	localparam int unsigned NSIZE_POS   = 94;
	localparam int unsigned SIZE_DIGITS = 8;
	localparam int unsigned TRAILER_LEN = 11;

	// member index counter
	localparam int unsigned INDEX_BITS = 16;
	localparam int unsigned INDEX_W    = 16;
	localparam logic [INDEX_W-1:0] INDEX_MAX =
		(INDEX_BITS >= 16) ? 16'hFFFF : INDEX_W'((64'd1 << INDEX_BITS) - 64'd1);

	localparam int unsigned LEN_W = 32;

	// byte role / parse phase
	typedef enum logic [2:0] {
		PH_HDR  = 3'd0,
		PH_NAME = 3'd1,
		PH_NPAD = 3'd2,
		PH_DATA = 3'd3,
		PH_DPAD = 3'd4,
		PH_PAST = 3'd5
	} phase_t;

	// one tagged output beat
	typedef struct packed {
		logic [7:0]         byte_out;
		phase_t             byte_role;
		logic [INDEX_W-1:0] member_index;
		logic [LEN_W-1:0]   name_length;
		logic [LEN_W-1:0]   data_length;
		logic               record_end;
		logic               is_trailer;
	} result_t;

	// ASCII hex digit to value; anything else reads as zero
	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39)
			v = 4'(c - 8'h30);
		else if (c >= 8'h41 && c <= 8'h46)
			v = 4'(c - 8'h41 + 8'd10);
		else if (c >= 8'h61 && c <= 8'h66)
			v = 4'(c - 8'h61 + 8'd10);
		return v;
	endfunction

	// "TRAILER!!!" followed by its terminator
	function automatic logic [7:0] trailer_char(input logic [3:0] i);
		logic [7:0] c;
		case (i)
			4'd0:    c = 8'h54;
			4'd1:    c = 8'h52;
			4'd2:    c = 8'h41;
			4'd3:    c = 8'h49;
			4'd4:    c = 8'h4C;
			4'd5:    c = 8'h45;
			4'd6:    c = 8'h52;
			4'd7:    c = 8'h21;
			4'd8:    c = 8'h21;
			4'd9:    c = 8'h21;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

@@ hdl/cpio_tagger.sv @@
// Record walker: phase state, size decode, trailer match, member counter.
// Depends on cpio_pkg.
module cpio_tagger (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        byte_in,
	output cpio_pkg::result_t res
);

	cpio_pkg::phase_t                  phase_q, phase_d;
	logic [cpio_pkg::LEN_W-1:0]        offset_q, offset_d;
	logic [cpio_pkg::LEN_W-1:0]        nsize_q, nsize_d;
	logic [cpio_pkg::LEN_W-1:0]        fsize_q, fsize_d;
	logic                              tmatch_q, tmatch_d;
	logic [cpio_pkg::INDEX_W-1:0]      count_q, count_d;

	logic                              is_hdr, is_name, is_past;
	logic [3:0]                        digit;
	logic [1:0]                        npad_len, dpad_len;
	logic [cpio_pkg::LEN_W-1:0]        len_cur;
	logic [cpio_pkg::LEN_W:0]          o_inc;
	logic                              done;
	logic [3:0]                        nonempty, cand;
	logic                              rec_end;
	logic                              known;

	assign is_hdr  = (phase_q == cpio_pkg::PH_HDR);
	assign is_name = (phase_q == cpio_pkg::PH_NAME);
	assign is_past = (phase_q == cpio_pkg::PH_PAST);
	assign digit   = cpio_pkg::hex_value(byte_in);

	// size fields shift in one hex digit per header byte
	always_comb begin
		fsize_d = fsize_q;
		nsize_d = nsize_q;
		if (is_hdr && offset_q >= cpio_pkg::LEN_W'(cpio_pkg::FSIZE_POS)
		    && offset_q < cpio_pkg::LEN_W'(cpio_pkg::FSIZE_POS + cpio_pkg::SIZE_DIGITS))
			fsize_d = {fsize_q[cpio_pkg::LEN_W-5:0], digit};
		if (is_hdr && offset_q >= cpio_pkg::LEN_W'(cpio_pkg::NSIZE_POS)
		    && offset_q < cpio_pkg::LEN_W'(cpio_pkg::NSIZE_POS + cpio_pkg::SIZE_DIGITS))
			nsize_d = {nsize_q[cpio_pkg::LEN_W-5:0], digit};
	end

	// trailer name compare
	always_comb begin
		tmatch_d = tmatch_q;
		if (is_hdr && offset_q == '0)
			tmatch_d = 1'b1;
		if (is_hdr && offset_q == cpio_pkg::LEN_W'(cpio_pkg::HDR_LEN - 1)
		    && nsize_d < cpio_pkg::LEN_W'(cpio_pkg::TRAILER_LEN))
			tmatch_d = 1'b0;
		if (is_name && offset_q < cpio_pkg::LEN_W'(cpio_pkg::TRAILER_LEN)
		    && byte_in != cpio_pkg::trailer_char(offset_q[3:0]))
			tmatch_d = 1'b0;
	end

	// padding: name pad counts from record start (header is 2 mod 4)
	assign npad_len = 2'(2'd0 - (2'(cpio_pkg::HDR_LEN) + nsize_d[1:0]));
	assign dpad_len = 2'(2'd0 - fsize_d[1:0]);

	always_comb begin
		case (phase_q)
			cpio_pkg::PH_HDR:  len_cur = cpio_pkg::LEN_W'(cpio_pkg::HDR_LEN);
			cpio_pkg::PH_NAME: len_cur = nsize_d;
			cpio_pkg::PH_NPAD: len_cur = {{(cpio_pkg::LEN_W-2){1'b0}}, npad_len};
			cpio_pkg::PH_DATA: len_cur = fsize_d;
			cpio_pkg::PH_DPAD: len_cur = {{(cpio_pkg::LEN_W-2){1'b0}}, dpad_len};
			default:           len_cur = '0;
		endcase
	end

	assign o_inc = {1'b0, offset_q} + 1'b1;
	assign done  = !is_past && (o_inc == {1'b0, len_cur});

	// parts still ahead of the current phase that are not empty
	assign nonempty = {dpad_len != 2'd0, fsize_d != '0, npad_len != 2'd0, nsize_d != '0};
	always_comb begin
		for (int k = 0; k < 4; k++)
			cand[k] = nonempty[k] && (3'(k + 1) > phase_q);
	end

	// next state
	always_comb begin
		phase_d  = phase_q;
		offset_d = offset_q;
		count_d  = count_q;
		rec_end  = 1'b0;
		if (!is_past) begin
			offset_d = o_inc[cpio_pkg::LEN_W-1:0];
			if (done) begin
				offset_d = '0;
				if (cand[0])
					phase_d = cpio_pkg::PH_NAME;
				else if (cand[1])
					phase_d = cpio_pkg::PH_NPAD;
				else if (cand[2])
					phase_d = cpio_pkg::PH_DATA;
				else if (cand[3])
					phase_d = cpio_pkg::PH_DPAD;
				else begin
					rec_end = 1'b1;
					if (tmatch_d)
						phase_d = cpio_pkg::PH_PAST;
					else begin
						phase_d = cpio_pkg::PH_HDR;
						if (count_q < cpio_pkg::INDEX_MAX)
							count_d = count_q + 1'b1;
					end
				end
			end
		end
	end

	// outputs for this byte
	assign known = is_past || (phase_q >= cpio_pkg::PH_NPAD)
	               || (is_name && o_inc == {1'b0, nsize_q});
	always_comb begin
		res.byte_out     = byte_in;
		res.byte_role    = phase_q;
		res.member_index = count_q;
		res.name_length  = is_hdr ? '0 : nsize_d;
		res.data_length  = is_hdr ? '0 : fsize_d;
		res.record_end   = rec_end;
		res.is_trailer   = known && tmatch_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= cpio_pkg::PH_HDR;
			offset_q <= '0;
			nsize_q  <= '0;
			fsize_q  <= '0;
			tmatch_q <= 1'b1;
			count_q  <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			offset_q <= offset_d;
			nsize_q  <= nsize_d;
			fsize_q  <= fsize_d;
			tmatch_q <= tmatch_d;
			count_q  <= count_d;
		end
	end

endmodule

@@ hdl/cpio_out_reg.sv @@
// Output register for tagged beats, held while the receiver stalls.
// Depends on cpio_pkg.
module cpio_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  cpio_pkg::result_t res_in,
	input  logic              take,
	output logic              valid,
	output cpio_pkg::result_t res_out
);

	logic              valid_q;
	cpio_pkg::result_t res_q;

	// valid: set on load, cleared when taken without a refill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load)
			valid_q <= 1'b1;
		else if (take)
			valid_q <= 1'b0;
	end

	// payload
	always_ff @(posedge clk) begin
		if (load)
			res_q <= res_in;
	end

	assign valid   = valid_q;
	assign res_out = res_q;

endmodule

@@ hdl/cpio_newc_stream_parser.sv @@
// Top level of the newc cpio stream parser: input register, tagger, output register.
// Depends on cpio_pkg, cpio_tagger, cpio_out_reg and the assertion macro header.
//
// Usage:
//   s_* takes one archive byte per beat (s_tdata[7:0]). m_* returns one tagged
//   beat per input beat, in order: the byte, its index, decoded lengths, role and
//   trailer flag. m_tlast marks the final byte of each member record.
//   An accepted byte is tagged and moves into the output register, which drives
//   m_*, when free or drained. Throughput: one byte per cycle while m_tready is high;
//   the record walker updates its phase counter and size decode once per byte.
//   When the receiver stalls, the output register holds its beat and the input
//   register takes one more byte; further bytes wait with s_tready low.
//   s_tready follows m_tready combinationally when both registers are full.
//   Reset empties both registers and puts the walker at the start of a header,
//   member index zero. After the trailer record, every byte is tagged as past
//   the end and the trailer's index and lengths are held.
`include "cpio_newc_stream_parser_macros.svh"

module cpio_newc_stream_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] archive_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // [7:0] byte_out, [23:8] member_index,
	                               // [55:24] name_length, [87:56] data_length
	output logic        m_tlast,   // record_end
	output logic [3:0]  m_tuser    // [2:0] byte_role, [3] is_trailer
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              step;
	logic              out_valid;
	cpio_pkg::result_t res_c, res_o;

	// a byte moves to the output register when that register is free or drains
	assign step     = valid_s1 && (!out_valid || m_tready);
	assign s_tready = !valid_s1 || step;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			byte_s1 <= s_tdata;
	end

	cpio_tagger u_tagger (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_in (byte_s1),
		.res     (res_c)
	);

	cpio_out_reg u_out_reg (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (step),
		.res_in  (res_c),
		.take    (m_tready),
		.valid   (out_valid),
		.res_out (res_o)
	);

	// beat packing
	assign m_tvalid = out_valid;
	assign m_tdata  = {res_o.data_length, res_o.name_length, res_o.member_index, res_o.byte_out};
	assign m_tlast  = res_o.record_end;
	assign m_tuser  = {res_o.is_trailer, res_o.byte_role};

	// checks
	`CPIO_ASSERT(a_past_implies_trailer, clk, arst_n, m_tvalid && (m_tuser[2:0] == cpio_pkg::PH_PAST) |-> m_tuser[3], "past-end beat without trailer flag")
	`CPIO_ASSERT(a_no_end_after_trailer, clk, arst_n, m_tvalid && m_tlast |-> (m_tuser[2:0] != cpio_pkg::PH_PAST), "record end tagged on past-end beat")
	`CPIO_ASSERT(a_hdr_lengths_zero, clk, arst_n, m_tvalid && (m_tuser[2:0] == cpio_pkg::PH_HDR) |-> (m_tdata[87:24] == '0), "header beat carries nonzero lengths")
	`CPIO_ASSERT(a_s1_holds, clk, arst_n, valid_s1 && !step |=> valid_s1 && $stable(byte_s1), "buffered byte lost while output stalled")

endmodule

@@ tb/cpio_tag_check.sv @@
// Scoreboard for the newc cpio stream parser: watches both stream channels,
// predicts the tag of every accepted archive byte and compares the output beats.
// Depends on cpio_pkg for the role enum, header layout and result layout.
`timescale 1ns / 1ps

module cpio_tag_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] archive_byte
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [87:0] m_tdata,   // [7:0] byte_out, [23:8] member_index,
	                               // [55:24] name_length, [87:56] data_length
	input  logic        m_tlast,   // record_end
	input  logic [3:0]  m_tuser,   // [2:0] byte_role, [3] is_trailer
	output int          mismatches,
	output int          outstanding
);

	// name of the end-of-archive record, terminator included, first char in the top byte
	localparam logic [87:0] TRAILER_NAME = {"TRAILER!!!", 8'h00};

	// record walker state
	cpio_pkg::phase_t walk_phase;
	logic [31:0]      walk_offset;
	logic [31:0]      nsize_acc;
	logic [31:0]      file_size;
	logic             name_is_trailer;
	logic [15:0]      member_cnt;

	cpio_pkg::result_t expected_tags[$];
	cpio_pkg::result_t want;
	cpio_pkg::result_t seen;

	// ASCII size digit; anything outside 0-9, A-F, a-f reads as zero
	function automatic logic [3:0] digit_value(input logic [7:0] c);
		if (c >= "0" && c <= "9")
			return c[3:0];
		if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f"))
			return c[3:0] + 4'd9;
		return 4'd0;
	endfunction

	// length of each part of the current record
	function automatic logic [31:0] part_length(input cpio_pkg::phase_t p);
		logic [31:0] npad_rem;
		logic [31:0] dpad_rem;
		npad_rem = 32'd0 - (cpio_pkg::HDR_LEN + nsize_acc);
		dpad_rem = 32'd0 - file_size;
		case (p)
			cpio_pkg::PH_HDR:  return cpio_pkg::HDR_LEN;
			cpio_pkg::PH_NAME: return nsize_acc;
			cpio_pkg::PH_NPAD: return {30'd0, npad_rem[1:0]};
			cpio_pkg::PH_DATA: return file_size;
			cpio_pkg::PH_DPAD: return {30'd0, dpad_rem[1:0]};
			default:           return 32'd0;
		endcase
	endfunction

	// advance the walker by one archive byte and build the tag it gets
	task automatic tag_archive_byte(input logic [7:0] b, output cpio_pkg::result_t tag);
		cpio_pkg::phase_t role;
		logic [15:0]      idx;
		logic             rec_end;
		logic             known;
		logic [31:0]      o;
		role    = walk_phase;
		idx     = member_cnt;
		rec_end = 1'b0;
		known   = 1'b0;
		if (walk_phase == cpio_pkg::PH_PAST) begin
			known = 1'b1;
		end else begin
			o = walk_offset;
			if (walk_phase == cpio_pkg::PH_HDR) begin
				if (o == 0)
					name_is_trailer = 1'b1;
				if (o >= cpio_pkg::FSIZE_POS && o < cpio_pkg::FSIZE_POS + cpio_pkg::SIZE_DIGITS)
					file_size = {file_size[27:0], digit_value(b)};
				if (o >= cpio_pkg::NSIZE_POS && o < cpio_pkg::NSIZE_POS + cpio_pkg::SIZE_DIGITS)
					nsize_acc = {nsize_acc[27:0], digit_value(b)};
				if (o == cpio_pkg::HDR_LEN - 1 && nsize_acc < cpio_pkg::TRAILER_LEN)
					name_is_trailer = 1'b0;
			end else if (walk_phase == cpio_pkg::PH_NAME) begin
				if (o < cpio_pkg::TRAILER_LEN
				    && b != TRAILER_NAME[8*(cpio_pkg::TRAILER_LEN-1-o) +: 8])
					name_is_trailer = 1'b0;
			end
			if (walk_phase >= cpio_pkg::PH_NPAD
			    || (walk_phase == cpio_pkg::PH_NAME && o + 1 == nsize_acc))
				known = 1'b1;

			// step through the parts, skipping empty ones
			walk_offset = o + 1;
			if (walk_offset == part_length(walk_phase)) begin
				walk_offset = 32'd0;
				walk_phase  = cpio_pkg::phase_t'(walk_phase + 1);
				while (walk_phase <= cpio_pkg::PH_DPAD && part_length(walk_phase) == 0)
					walk_phase = cpio_pkg::phase_t'(walk_phase + 1);
				if (walk_phase > cpio_pkg::PH_DPAD) begin
					rec_end = 1'b1;
					if (name_is_trailer) begin
						walk_phase = cpio_pkg::PH_PAST;
					end else begin
						walk_phase = cpio_pkg::PH_HDR;
						if (member_cnt < cpio_pkg::INDEX_MAX)
							member_cnt = member_cnt + 16'd1;
					end
				end
			end
		end

		tag.byte_out     = b;
		tag.byte_role    = role;
		tag.member_index = idx;
		tag.name_length  = (role == cpio_pkg::PH_HDR) ? 32'd0 : nsize_acc;
		tag.data_length  = (role == cpio_pkg::PH_HDR) ? 32'd0 : file_size;
		tag.record_end   = rec_end;
		tag.is_trailer   = known && name_is_trailer;
	endtask

	// predict on input beats, compare on output beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_phase      = cpio_pkg::PH_HDR;
			walk_offset     = 32'd0;
			nsize_acc       = 32'd0;
			file_size       = 32'd0;
			name_is_trailer = 1'b1;
			member_cnt      = 16'd0;
			expected_tags.delete();
			mismatches      = 0;
			outstanding     = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				tag_archive_byte(s_tdata, want);
				expected_tags.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				seen.byte_out     = m_tdata[7:0];
				seen.member_index = m_tdata[23:8];
				seen.name_length  = m_tdata[55:24];
				seen.data_length  = m_tdata[87:56];
				seen.byte_role    = cpio_pkg::phase_t'(m_tuser[2:0]);
				seen.is_trailer   = m_tuser[3];
				seen.record_end   = m_tlast;
				if (expected_tags.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: output beat with nothing pending: byte=%h role=%0d",
							$realtime, seen.byte_out, seen.byte_role);
					mismatches++;
				end else begin
					want = expected_tags.pop_front();
					if (seen.byte_out !== want.byte_out || seen.byte_role !== want.byte_role ||
					    seen.member_index !== want.member_index ||
					    seen.name_length !== want.name_length ||
					    seen.data_length !== want.data_length ||
					    seen.record_end !== want.record_end ||
					    seen.is_trailer !== want.is_trailer) begin
						if (mismatches < 10) begin
							$display("%0t: exp byte=%h role=%0d idx=%0d nlen=%h dlen=%h last=%b trl=%b",
								$realtime, want.byte_out, want.byte_role, want.member_index,
								want.name_length, want.data_length, want.record_end,
								want.is_trailer);
							$display("%0t: got byte=%h role=%0d idx=%0d nlen=%h dlen=%h last=%b trl=%b",
								$realtime, seen.byte_out, seen.byte_role, seen.member_index,
								seen.name_length, seen.data_length, seen.record_end,
								seen.is_trailer);
						end
						mismatches++;
					end
				end
			end
			outstanding = expected_tags.size();
		end
	end

endmodule

@@ tb/testbench.sv @@
// Top of the parser testbench: builds a byte stream of newc records, drives it with
// random gaps and output stalls, and reports the verdict from the scoreboard.
// Depends on cpio_pkg, cpio_newc_stream_parser and cpio_tag_check.
`timescale 1ns / 1ps

module testbench;

	localparam int          PAST_BYTES     = 16;
	localparam int          LONG_HOLD      = 64;
	localparam int          WATCHDOG_LIMIT = 2000;
	localparam logic [47:0] CPIO_MAGIC     = "070701";
	localparam logic [87:0] TRAILER_TEXT   = {"TRAILER!!!", 8'h00};

	// how the name bytes of a record are made
	typedef enum logic [1:0] {
		NAME_RANDOM,    // arbitrary bytes
		NAME_TRAILER,   // end-of-archive name, then arbitrary bytes
		NAME_SPOILED    // end-of-archive name with one byte changed
	} name_style_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [87:0] m_tdata;
	logic        m_tlast;
	logic [3:0]  m_tuser;

	int mismatches;
	int outstanding;

	logic [7:0] archive_bytes[$];
	bit         hold_request;
	bit         hold_done;
	bit         quiet_tail;
	int         stall_cycles;

	cpio_newc_stream_parser uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	cpio_tag_check u_tag_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.m_tuser     (m_tuser),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// eight hex digits for a size, most significant digit in the top byte;
	// noisy text spells some zero digits as non-hex characters
	function automatic logic [63:0] size_text(input logic [31:0] v, input bit noisy);
		logic [63:0] txt;
		logic [3:0]  nib;
		logic [7:0]  c;
		int          k;
		for (k = 0; k < 8; k++) begin
			nib = v[4*k +: 4];
			if (nib < 4'd10)
				c = "0" + nib;
			else if ($urandom_range(0, 1))
				c = "A" + nib - 8'd10;
			else
				c = "a" + nib - 8'd10;
			if (noisy && nib == 4'd0 && $urandom_range(0, 1)) begin
				c = 8'($urandom_range(0, 255));
				if ((c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f"))
					c = "?";
			end
			txt[8*k +: 8] = c;
		end
		return txt;
	endfunction

	// append one whole record: header, name, name pad, data, data pad
	task automatic append_member(input logic [31:0] name_sz, input logic [31:0] file_sz,
	                             input name_style_t style, input bit noisy, input bit junk_magic);
		logic [63:0] ftxt;
		logic [63:0] ntxt;
		logic [7:0]  c;
		int          o;
		int          i;
		int          pad;
		int          bad_at;
		ftxt   = size_text(file_sz, noisy);
		ntxt   = size_text(name_sz, noisy);
		bad_at = $urandom_range(0, cpio_pkg::TRAILER_LEN - 1);
		for (o = 0; o < cpio_pkg::HDR_LEN; o++) begin
			if (o < 6 && !junk_magic)
				c = CPIO_MAGIC[8*(5-o) +: 8];
			else if (o >= cpio_pkg::FSIZE_POS && o < cpio_pkg::FSIZE_POS + cpio_pkg::SIZE_DIGITS)
				c = ftxt[8*(cpio_pkg::FSIZE_POS+7-o) +: 8];
			else if (o >= cpio_pkg::NSIZE_POS && o < cpio_pkg::NSIZE_POS + cpio_pkg::SIZE_DIGITS)
				c = ntxt[8*(cpio_pkg::NSIZE_POS+7-o) +: 8];
			else
				c = 8'($urandom_range(0, 255));
			archive_bytes.push_back(c);
		end
		for (i = 0; i < name_sz; i++) begin
			c = 8'($urandom_range(0, 255));
			if (style != NAME_RANDOM && i < cpio_pkg::TRAILER_LEN)
				c = TRAILER_TEXT[8*(cpio_pkg::TRAILER_LEN-1-i) +: 8];
			if (style == NAME_SPOILED && i == bad_at)
				c = ~c;
			archive_bytes.push_back(c);
		end
		pad = (4 - ((cpio_pkg::HDR_LEN + name_sz) % 4)) % 4;
		for (i = 0; i < pad; i++)
			archive_bytes.push_back(8'($urandom_range(0, 255)));
		for (i = 0; i < file_sz; i++)
			archive_bytes.push_back(8'($urandom_range(0, 255)));
		pad = (4 - (file_sz % 4)) % 4;
		for (i = 0; i < pad; i++)
			archive_bytes.push_back(8'($urandom_range(0, 255)));
	endtask

	// watchdog: too long without any beat on either side
	initial begin
		stall_cycles = 0;
		while (stall_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("== FAIL ==");
		$finish;
	end

	// receiver: random stall bursts, one long hold-off, none in the tail
	initial begin
		m_tready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_request && !hold_done) begin
				m_tready  <= 1'b0;
				hold_done = 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	// stimulus and verdict
	initial begin
		int k;
		int hold_at;
		int tail_start;

		arst_n       <= 1'b0;
		s_tvalid     <= 1'b0;
		s_tdata      <= 8'd0;
		hold_request = 1'b0;
		hold_done    = 1'b0;
		quiet_tail   = 1'b0;

		// trailer text with a short size: record ends on its last name byte,
		// junk magic and non-hex size digits
		append_member(cpio_pkg::TRAILER_LEN - 1, 0, NAME_TRAILER, 1, 1);
		// near miss on the trailer name, mixed-case hex digits
		append_member(cpio_pkg::TRAILER_LEN, 26, NAME_SPOILED, 0, 0);

		// end of archive, with trailing garbage
		append_member(cpio_pkg::TRAILER_LEN + $urandom_range(0, 4), $urandom_range(0, 9),
			NAME_TRAILER, 1'($urandom_range(0, 1)), 0);
		for (k = 0; k < PAST_BYTES; k++)
			archive_bytes.push_back(8'($urandom_range(0, 255)));

		hold_at    = archive_bytes.size() / 3;
		tail_start = (archive_bytes.size() * 85) / 100;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// byte stream with random gaps
		for (k = 0; k < archive_bytes.size(); k++) begin
			if (k == hold_at)
				hold_request = 1'b1;
			if (k >= tail_start)
				quiet_tail = 1'b1;
			if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= archive_bytes[k];
			@(posedge clk);
			while (!s_tready)
				@(posedge clk);
		end
		s_tvalid <= 1'b0;

		// drain, then wait on for any stray beats
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
